FILE: rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 arithmetic unit package
// Shared types, command codes and constants for the fixed-point unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DefaultFractionBits = 8;

   localparam logic signed [31:0] MaxValue = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MinValue = 32'sh8000_0000;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_GT       = 4'd4,
      CMD_LT       = 4'd5,
      CMD_GE       = 4'd6,
      CMD_LE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_MIN      = 4'd10,
      CMD_MAX      = 4'd11,
      CMD_INC      = 4'd12,
      CMD_DEC      = 4'd13,
      CMD_TO_INT   = 4'd14,
      CMD_FROM_INT = 4'd15
   } cmd_type;

   typedef struct packed {
      logic [3:0]         command;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               compare_true;
      logic               overflow_flag;
      logic               divide_by_zero;
   } rsp_payload_type;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] simple_value;
      logic               simple_cmp;
      logic               simple_ovf;
      logic               div_zero;
      logic               quo_neg;
      logic signed [63:0] product;
   } side_type;

endpackage

FILE: rtl/core/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Registers the transaction, evaluates the simple commands, forms the
// product and prepares operand magnitudes for the divider.
// ----------------------------------------------------------------------------
module fpa_front #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  fpa_pkg::req_payload_type in_payload,
   output logic                     out_valid,
   output fpa_pkg::side_type        out_side,
   output logic [31+FRACTION_BITS:0] out_dividend,
   output logic [31:0]              out_divisor
);
   import fpa_pkg::*;

   logic            s1_valid_ff;
   req_payload_type s1_payload_ff;
   logic            s2_valid_ff;
   side_type        s2_side_ff;
   logic [31+FRACTION_BITS:0] s2_dividend_ff;
   logic [31:0]     s2_divisor_ff;

   side_type        side_in;
   logic [31+FRACTION_BITS:0] dividend_in;
   logic [31:0]     divisor_in;

   logic signed [31:0] a;
   logic signed [31:0] b;
   logic signed [32:0] sum;
   logic signed [32:0] diff;
   logic signed [32:0] incr;
   logic signed [32:0] decr;
   logic signed [31+FRACTION_BITS:0] wide;
   logic [FRACTION_BITS:0] wide_top;
   logic [31:0] a_mag;
   logic [31:0] b_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_payload_ff  <= in_payload;
         s2_side_ff     <= side_in;
         s2_dividend_ff <= dividend_in;
         s2_divisor_ff  <= divisor_in;
      end
   end

   always_comb begin
      a        = s1_payload_ff.operand_a;
      b        = s1_payload_ff.operand_b;
      sum      = {a[31], a} + {b[31], b};
      diff     = {a[31], a} - {b[31], b};
      incr     = {a[31], a} + 33'sd1;
      decr     = {a[31], a} - 33'sd1;
      wide     = {a, {FRACTION_BITS{1'b0}}};
      wide_top = wide[31+FRACTION_BITS:31];
      a_mag    = a[31] ? 32'(-a) : 32'(a);
      b_mag    = b[31] ? 32'(-b) : 32'(b);

      side_in              = '0;
      side_in.cmd          = cmd_type'(s1_payload_ff.command);
      side_in.product      = a * b;
      side_in.quo_neg      = a[31] ^ b[31];
      dividend_in          = {a_mag, {FRACTION_BITS{1'b0}}};
      divisor_in           = (b == 32'sd0) ? 32'd1 : b_mag;

      unique case (cmd_type'(s1_payload_ff.command))
         CMD_ADD: begin
            side_in.simple_ovf   = sum[32] ^ sum[31];
            side_in.simple_value = side_in.simple_ovf ?
               (sum[32] ? MinValue : MaxValue) : sum[31:0];
         end
         CMD_SUB: begin
            side_in.simple_ovf   = diff[32] ^ diff[31];
            side_in.simple_value = side_in.simple_ovf ?
               (diff[32] ? MinValue : MaxValue) : diff[31:0];
         end
         CMD_MUL: begin
            side_in.simple_value = '0;
         end
         CMD_DIV: begin
            if (b == 32'sd0) begin
               side_in.div_zero     = 1'b1;
               side_in.simple_value = a[31] ? MinValue : MaxValue;
            end
         end
         CMD_GT:  side_in.simple_cmp = (a > b);
         CMD_LT:  side_in.simple_cmp = (a < b);
         CMD_GE:  side_in.simple_cmp = (a >= b);
         CMD_LE:  side_in.simple_cmp = (a <= b);
         CMD_EQ:  side_in.simple_cmp = (a == b);
         CMD_NE:  side_in.simple_cmp = (a != b);
         CMD_MIN: side_in.simple_value = (a < b) ? a : b;
         CMD_MAX: side_in.simple_value = (a > b) ? a : b;
         CMD_INC: begin
            side_in.simple_ovf   = incr[32] ^ incr[31];
            side_in.simple_value = side_in.simple_ovf ? MaxValue : incr[31:0];
         end
         CMD_DEC: begin
            side_in.simple_ovf   = decr[32] ^ decr[31];
            side_in.simple_value = side_in.simple_ovf ? MinValue : decr[31:0];
         end
         CMD_TO_INT: side_in.simple_value = a >>> FRACTION_BITS;
         CMD_FROM_INT: begin
            side_in.simple_ovf   = !((&wide_top) || !(|wide_top));
            side_in.simple_value = side_in.simple_ovf ?
               (a[31] ? MinValue : MaxValue) : wide[31:0];
         end
         default: side_in.simple_value = '0;
      endcase
   end

   assign out_valid    = s2_valid_ff;
   assign out_side     = s2_side_ff;
   assign out_dividend = s2_dividend_ff;
   assign out_divisor  = s2_divisor_ff;

endmodule

FILE: rtl/core/fpa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpa_divider #(
   parameter int DIVIDEND_WIDTH = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  fpa_pkg::side_type         in_side,
   input  logic [DIVIDEND_WIDTH-1:0] in_dividend,
   input  logic [31:0]               in_divisor,
   output logic                      out_valid,
   output fpa_pkg::side_type         out_side,
   output logic [DIVIDEND_WIDTH-1:0] out_quotient,
   output logic [31:0]               out_remainder,
   output logic [31:0]               out_divisor
);
   import fpa_pkg::*;

   logic                      vld_ff  [DIVIDEND_WIDTH];
   side_type                  side_ff [DIVIDEND_WIDTH];
   logic [31:0]               rem_ff  [DIVIDEND_WIDTH];
   logic [DIVIDEND_WIDTH-1:0] dq_ff   [DIVIDEND_WIDTH];
   logic [31:0]               dv_ff   [DIVIDEND_WIDTH];

   for (genvar g = 0; g < DIVIDEND_WIDTH; g++) begin : g_stage
      logic                      src_vld;
      side_type                  src_side;
      logic [31:0]               src_rem;
      logic [DIVIDEND_WIDTH-1:0] src_dq;
      logic [31:0]               src_dv;
      logic [32:0]               trial;
      logic                      ge;

      if (g == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_side = in_side;
         assign src_rem  = '0;
         assign src_dq   = in_dividend;
         assign src_dv   = in_divisor;
      end else begin : g_next
         assign src_vld  = vld_ff[g-1];
         assign src_side = side_ff[g-1];
         assign src_rem  = rem_ff[g-1];
         assign src_dq   = dq_ff[g-1];
         assign src_dv   = dv_ff[g-1];
      end

      assign trial = {src_rem, src_dq[DIVIDEND_WIDTH-1]};
      assign ge    = (trial >= {1'b0, src_dv});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (enable) begin
            vld_ff[g] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[g] <= src_side;
            rem_ff[g]  <= ge ? 32'(trial - {1'b0, src_dv}) : trial[31:0];
            dq_ff[g]   <= {src_dq[DIVIDEND_WIDTH-2:0], ge};
            dv_ff[g]   <= src_dv;
         end
      end
   end

   assign out_valid     = vld_ff[DIVIDEND_WIDTH-1];
   assign out_side      = side_ff[DIVIDEND_WIDTH-1];
   assign out_quotient  = dq_ff[DIVIDEND_WIDTH-1];
   assign out_remainder = rem_ff[DIVIDEND_WIDTH-1];
   assign out_divisor   = dv_ff[DIVIDEND_WIDTH-1];

endmodule

FILE: rtl/core/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Rounds the product and the quotient half away from zero, applies the sign,
// saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module fpa_back #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  fpa_pkg::side_type         in_side,
   input  logic [31+FRACTION_BITS:0] in_quotient,
   input  logic [31:0]               in_remainder,
   input  logic [31:0]               in_divisor,
   output logic                      out_valid,
   output fpa_pkg::rsp_payload_type  out_payload
);
   import fpa_pkg::*;

   logic            a_valid_ff;
   side_type        a_side_ff;
   logic [63:0]     a_mag_ff;
   logic [63:0]     a_mag_in;
   logic            b_valid_ff;
   rsp_payload_type b_payload_ff;
   rsp_payload_type b_payload_in;

   logic [63:0] prod_mag;
   logic [63:0] prod_quo;
   logic [32+FRACTION_BITS:0] div_quo;
   logic        neg;

   always_comb begin
      prod_mag = in_side.product[63] ? 64'(-in_side.product) : 64'(in_side.product);
      prod_quo = (prod_mag >> FRACTION_BITS) + 64'(prod_mag[FRACTION_BITS-1]);
      div_quo  = {1'b0, in_quotient} +
                 (33+FRACTION_BITS)'({in_remainder, 1'b0} >= {1'b0, in_divisor});
      a_mag_in = (in_side.cmd == CMD_MUL) ? prod_quo : 64'(div_quo);
   end

   always_comb begin
      neg          = (a_side_ff.cmd == CMD_MUL) ? a_side_ff.product[63] : a_side_ff.quo_neg;
      b_payload_in = '0;
      if ((a_side_ff.cmd == CMD_MUL) ||
          ((a_side_ff.cmd == CMD_DIV) && !a_side_ff.div_zero)) begin
         if (neg) begin
            if (a_mag_ff > 64'h0000_0000_8000_0000) begin
               b_payload_in.overflow_flag = 1'b1;
               b_payload_in.result_value  = MinValue;
            end else begin
               b_payload_in.result_value  = 32'(-a_mag_ff[31:0]);
            end
         end else begin
            if (a_mag_ff > 64'h0000_0000_7FFF_FFFF) begin
               b_payload_in.overflow_flag = 1'b1;
               b_payload_in.result_value  = MaxValue;
            end else begin
               b_payload_in.result_value  = a_mag_ff[31:0];
            end
         end
      end else begin
         b_payload_in.result_value   = a_side_ff.simple_value;
         b_payload_in.compare_true   = a_side_ff.simple_cmp;
         b_payload_in.overflow_flag  = a_side_ff.simple_ovf;
         b_payload_in.divide_by_zero = a_side_ff.div_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_side_ff    <= in_side;
         a_mag_ff     <= a_mag_in;
         b_payload_ff <= b_payload_in;
      end
   end

   assign out_valid   = b_valid_ff;
   assign out_payload = b_payload_ff;

endmodule

FILE: rtl/core/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q24.8 fixed-point arithmetic unit
// Throughput is one transaction per cycle unless a pending result stalls the
// pipeline; the divider takes one quotient bit per stage, which sets the
// pipeline depth.
// Synchronous reset clears every valid bit; the data registers keep theirs.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8
   import fpa_pkg::*;
#(
   parameter int FRACTION_BITS = DefaultFractionBits
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fpa_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fpa_pkg::rsp_payload_type rsp_payload
);

   localparam int DividendWidth = 32 + FRACTION_BITS;

   logic                     enable;
   logic                     fe_valid;
   side_type                 fe_side;
   logic [DividendWidth-1:0] fe_dividend;
   logic [31:0]              fe_divisor;
   logic                     dv_valid;
   side_type                 dv_side;
   logic [DividendWidth-1:0] dv_quotient;
   logic [31:0]              dv_remainder;
   logic [31:0]              dv_divisor;

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (req_valid),
      .in_payload   (req_payload),
      .out_valid    (fe_valid),
      .out_side     (fe_side),
      .out_dividend (fe_dividend),
      .out_divisor  (fe_divisor)
   );

   fpa_divider #(.DIVIDEND_WIDTH(DividendWidth)) u_divider (
      .clock         (clock),
      .reset         (reset),
      .enable        (enable),
      .in_valid      (fe_valid),
      .in_side       (fe_side),
      .in_dividend   (fe_dividend),
      .in_divisor    (fe_divisor),
      .out_valid     (dv_valid),
      .out_side      (dv_side),
      .out_quotient  (dv_quotient),
      .out_remainder (dv_remainder),
      .out_divisor   (dv_divisor)
   );

   fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (dv_valid),
      .in_side      (dv_side),
      .in_quotient  (dv_quotient),
      .in_remainder (dv_remainder),
      .in_divisor   (dv_divisor),
      .out_valid    (rsp_valid),
      .out_payload  (rsp_payload)
   );

`ifndef SYNTHESIS
   a_dz_no_ovf : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.divide_by_zero |-> !rsp_payload.overflow_flag)
      else $error("Division by zero transaction also flags overflow.");

   a_cmp_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.compare_true |-> rsp_payload.result_value == 32'sd0)
      else $error("Comparison transaction carries a non-zero value.");

   a_ovf_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow_flag |->
         (rsp_payload.result_value == MaxValue) || (rsp_payload.result_value == MinValue))
      else $error("Overflow flagged without a saturated value.");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled result changed.");
`endif

endmodule
